FILE: rtl/core/dtu_pkg.sv
// Shared types, constants and decode functions for the DVB text to UTF-8 block.
`timescale 1ns / 1ps

package dtu_pkg;

    // Width of the running output byte count
    localparam int LENGTH_BITS = 16;
    localparam int SUM_W       = 34;
    localparam logic [SUM_W-1:0] CNT_MAX = (SUM_W'(1) << LENGTH_BITS) - SUM_W'(1);

    // Reset value of the output capacity register
    localparam logic [15:0] CAP_RESET = 16'd256;

    // Run queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Selector bytes
    localparam logic [7:0] SEL_CYR    = 8'h01;
    localparam logic [7:0] SEL_GREEK  = 8'h03;
    localparam logic [7:0] SEL_LATIN5 = 8'h05;
    localparam logic [7:0] SEL_LATIN9 = 8'h0B;
    localparam logic [7:0] SEL_EXT    = 8'h10;
    localparam logic [7:0] SEL_UTF16  = 8'h11;
    localparam logic [7:0] SEL_UTF8   = 8'h15;
    localparam logic [7:0] SEL_SKIP   = 8'h1F;

    // Third byte of the three-byte selector
    localparam logic [7:0] EXT_CYR    = 8'h05;
    localparam logic [7:0] EXT_GREEK  = 8'h07;
    localparam logic [7:0] EXT_LATIN5 = 8'h09;
    localparam logic [7:0] EXT_LATIN9 = 8'h0F;

    typedef enum logic [2:0] {
        PH_SELECT,
        PH_TEXT,
        PH_EXT1,
        PH_EXT2,
        PH_SKIP1
    } phase_t;

    typedef enum logic [2:0] {
        T_ISO6937,
        T_LATIN1,
        T_LATIN5,
        T_LATIN9,
        T_CYR,
        T_GREEK,
        T_UTF8,
        T_UTF16
    } table_t;

    // Encoded code point: up to three bytes, first byte in element 0
    typedef struct packed {
        logic            ok;
        logic [1:0]      n;
        logic [2:0][7:0] b;
    } enc_t;

    // One queue entry: the beats caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      num;
        logic            closing;
        logic [15:0]     length;
    } run_t;

    // Check that n more bytes plus a terminator still fit
    function automatic logic room_ok(input logic [LENGTH_BITS-1:0] bw,
                                     input logic [2:0] n,
                                     input logic [15:0] cap);
        logic [SUM_W-1:0] s;
        s = SUM_W'(bw) + SUM_W'(n);
        return ((s + SUM_W'(1)) <= SUM_W'(cap)) && (s <= CNT_MAX);
    endfunction

    // Encode one code point as UTF-8 if it fits
    function automatic enc_t utf8_encode(input logic [15:0] code,
                                         input logic [LENGTH_BITS-1:0] bw,
                                         input logic [15:0] cap);
        enc_t r;
        logic [1:0] need;
        r    = '0;
        need = (code < 16'h0080) ? 2'd1 : (code < 16'h0800) ? 2'd2 : 2'd3;
        if (code == 16'h0000) begin
            r.ok = 1'b1;
        end else if (room_ok(bw, 3'(need), cap)) begin
            r.ok = 1'b1;
            r.n  = need;
            case (need)
                2'd1: r.b[0] = code[7:0];
                2'd2:
                begin
                    r.b[0] = {3'b110, code[10:6]};
                    r.b[1] = {2'b10, code[5:0]};
                end
                default:
                begin
                    r.b[0] = {4'hE, code[15:12]};
                    r.b[1] = {2'b10, code[11:6]};
                    r.b[2] = {2'b10, code[5:0]};
                end
            endcase
        end
        return r;
    endfunction

    // ISO 6937 bytes 0xA0..0xFF that are not marks
    function automatic logic [15:0] t6937_code(input logic [7:0] b);
        case (b)
            8'hA0: return 16'h00A0; 8'hA1: return 16'h00A1; 8'hA2: return 16'h00A2;
            8'hA3: return 16'h00A3; 8'hA4: return 16'h20AC; 8'hA5: return 16'h00A5;
            8'hA7: return 16'h00A7; 8'hA8: return 16'h00A4; 8'hA9: return 16'h2018;
            8'hAA: return 16'h201C; 8'hAB: return 16'h00AB; 8'hAC: return 16'h2190;
            8'hAD: return 16'h2191; 8'hAE: return 16'h2192; 8'hAF: return 16'h2193;
            8'hB0: return 16'h00B0; 8'hB1: return 16'h00B1; 8'hB2: return 16'h00B2;
            8'hB3: return 16'h00B3; 8'hB4: return 16'h00D7; 8'hB5: return 16'h00B5;
            8'hB6: return 16'h00B6; 8'hB7: return 16'h00B7; 8'hB8: return 16'h00F7;
            8'hB9: return 16'h2019; 8'hBA: return 16'h201D; 8'hBB: return 16'h00BB;
            8'hBC: return 16'h00BC; 8'hBD: return 16'h00BD; 8'hBE: return 16'h00BE;
            8'hBF: return 16'h00BF;
            8'hD0: return 16'h2015; 8'hD1: return 16'h00B9; 8'hD2: return 16'h00AE;
            8'hD3: return 16'h00A9; 8'hD4: return 16'h2122; 8'hD5: return 16'h266A;
            8'hD6: return 16'h00AC; 8'hD7: return 16'h00A6;
            8'hDC: return 16'h215B; 8'hDD: return 16'h215C; 8'hDE: return 16'h215D;
            8'hDF: return 16'h215E;
            8'hE0: return 16'h2126; 8'hE1: return 16'h00C6; 8'hE2: return 16'h0110;
            8'hE3: return 16'h00AA; 8'hE4: return 16'h0126; 8'hE6: return 16'h0132;
            8'hE7: return 16'h013F; 8'hE8: return 16'h0141; 8'hE9: return 16'h00D8;
            8'hEA: return 16'h0152; 8'hEB: return 16'h00BA; 8'hEC: return 16'h00DE;
            8'hED: return 16'h0166; 8'hEE: return 16'h014A; 8'hEF: return 16'h0149;
            8'hF0: return 16'h0138; 8'hF1: return 16'h00E6; 8'hF2: return 16'h0111;
            8'hF3: return 16'h00F0; 8'hF4: return 16'h0127; 8'hF5: return 16'h0131;
            8'hF6: return 16'h0133; 8'hF7: return 16'h0140; 8'hF8: return 16'h0142;
            8'hF9: return 16'h00F8; 8'hFA: return 16'h0153; 8'hFB: return 16'h00DF;
            8'hFC: return 16'h00FE; 8'hFD: return 16'h0167; 8'hFE: return 16'h014B;
            8'hFF: return 16'h00AD;
            default: return 16'h0000;
        endcase
    endfunction

    // Combining mark for a pending ISO 6937 mark index
    function automatic logic [15:0] mark_code(input logic [3:0] pm);
        case (pm)
            4'd1:  return 16'h0300; 4'd2:  return 16'h0301; 4'd3:  return 16'h0302;
            4'd4:  return 16'h0303; 4'd5:  return 16'h0304; 4'd6:  return 16'h0306;
            4'd7:  return 16'h0307; 4'd8:  return 16'h0308; 4'd10: return 16'h030A;
            4'd11: return 16'h0327; 4'd13: return 16'h030B; 4'd14: return 16'h0328;
            4'd15: return 16'h030C;
            default: return 16'h0000;
        endcase
    endfunction

    // Precomposed letter for a mark index and base letter, zero if none
    function automatic logic [15:0] compose(input logic [3:0] pm, input logic [7:0] c);
        case (pm)
            4'd1:
                case (c)
                    "A": return 16'h00C0; "E": return 16'h00C8; "I": return 16'h00CC;
                    "O": return 16'h00D2; "U": return 16'h00D9; "a": return 16'h00E0;
                    "e": return 16'h00E8; "i": return 16'h00EC; "o": return 16'h00F2;
                    "u": return 16'h00F9;
                    default: return 16'h0000;
                endcase
            4'd2:
                case (c)
                    "A": return 16'h00C1; "C": return 16'h0106; "E": return 16'h00C9;
                    "I": return 16'h00CD; "N": return 16'h0143; "O": return 16'h00D3;
                    "S": return 16'h015A; "U": return 16'h00DA; "Y": return 16'h00DD;
                    "Z": return 16'h0179; "a": return 16'h00E1; "c": return 16'h0107;
                    "e": return 16'h00E9; "i": return 16'h00ED; "n": return 16'h0144;
                    "o": return 16'h00F3; "s": return 16'h015B; "u": return 16'h00FA;
                    "y": return 16'h00FD; "z": return 16'h017A;
                    default: return 16'h0000;
                endcase
            4'd3:
                case (c)
                    "A": return 16'h00C2; "E": return 16'h00CA; "I": return 16'h00CE;
                    "O": return 16'h00D4; "U": return 16'h00DB; "a": return 16'h00E2;
                    "e": return 16'h00EA; "i": return 16'h00EE; "o": return 16'h00F4;
                    "u": return 16'h00FB;
                    default: return 16'h0000;
                endcase
            4'd4:
                case (c)
                    "A": return 16'h00C3; "N": return 16'h00D1; "O": return 16'h00D5;
                    "a": return 16'h00E3; "n": return 16'h00F1; "o": return 16'h00F5;
                    default: return 16'h0000;
                endcase
            4'd6:
                case (c)
                    "A": return 16'h0102; "G": return 16'h011E; "a": return 16'h0103;
                    "g": return 16'h011F;
                    default: return 16'h0000;
                endcase
            4'd7:
                case (c)
                    "I": return 16'h0130; "Z": return 16'h017B; "z": return 16'h017C;
                    default: return 16'h0000;
                endcase
            4'd8:
                case (c)
                    "A": return 16'h00C4; "E": return 16'h00CB; "I": return 16'h00CF;
                    "O": return 16'h00D6; "U": return 16'h00DC; "Y": return 16'h0178;
                    "a": return 16'h00E4; "e": return 16'h00EB; "i": return 16'h00EF;
                    "o": return 16'h00F6; "u": return 16'h00FC; "y": return 16'h00FF;
                    default: return 16'h0000;
                endcase
            4'd10:
                case (c)
                    "A": return 16'h00C5; "U": return 16'h016E; "a": return 16'h00E5;
                    "u": return 16'h016F;
                    default: return 16'h0000;
                endcase
            4'd11:
                case (c)
                    "C": return 16'h00C7; "G": return 16'h0122; "S": return 16'h015E;
                    "T": return 16'h0162; "c": return 16'h00E7; "g": return 16'h0123;
                    "s": return 16'h015F; "t": return 16'h0163;
                    default: return 16'h0000;
                endcase
            4'd13:
                case (c)
                    "O": return 16'h0150; "U": return 16'h0170; "o": return 16'h0151;
                    "u": return 16'h0171;
                    default: return 16'h0000;
                endcase
            4'd14:
                case (c)
                    "A": return 16'h0104; "E": return 16'h0118; "a": return 16'h0105;
                    "e": return 16'h0119;
                    default: return 16'h0000;
                endcase
            4'd15:
                case (c)
                    "C": return 16'h010C; "D": return 16'h010E; "E": return 16'h011A;
                    "N": return 16'h0147; "R": return 16'h0158; "S": return 16'h0160;
                    "T": return 16'h0164; "Z": return 16'h017D; "c": return 16'h010D;
                    "d": return 16'h010F; "e": return 16'h011B; "n": return 16'h0148;
                    "r": return 16'h0159; "s": return 16'h0161; "t": return 16'h0165;
                    "z": return 16'h017E;
                    default: return 16'h0000;
                endcase
            default: return 16'h0000;
        endcase
    endfunction

    // Greek bytes 0xA0..0xB5
    function automatic logic [15:0] greek_a0(input logic [7:0] b);
        case (b)
            8'hA1: return 16'h2018; 8'hA2: return 16'h2019; 8'hA4: return 16'h20AC;
            8'hA5: return 16'h20AF; 8'hAA: return 16'h037A; 8'hAE: return 16'h0000;
            8'hAF: return 16'h2015; 8'hB4: return 16'h0384; 8'hB5: return 16'h0385;
            default: return {8'h00, b};
        endcase
    endfunction

    // Code point of a byte 0xA0..0xFF in the 8859 tables
    function automatic logic [15:0] high_code(input table_t t, input logic [7:0] b);
        logic [15:0] w;
        w = {8'h00, b};
        case (t)
            T_LATIN5:
                case (b)
                    8'hD0: return 16'h011E; 8'hDD: return 16'h0130; 8'hDE: return 16'h015E;
                    8'hF0: return 16'h011F; 8'hFD: return 16'h0131; 8'hFE: return 16'h015F;
                    default: return w;
                endcase
            T_LATIN9:
                case (b)
                    8'hA4: return 16'h20AC; 8'hA6: return 16'h0160; 8'hA8: return 16'h0161;
                    8'hB4: return 16'h017D; 8'hB8: return 16'h017E; 8'hBC: return 16'h0152;
                    8'hBD: return 16'h0153; 8'hBE: return 16'h0178;
                    default: return w;
                endcase
            T_CYR:
            begin
                if (b == 8'hA0 || b == 8'hAD) return w;
                if (b == 8'hF0) return 16'h2116;
                if (b == 8'hFD) return 16'h00A7;
                if (b <= 8'hAC) return w + 16'h0401 - 16'h00A1;
                if (b <= 8'hAF) return w + 16'h040E - 16'h00AE;
                if (b <= 8'hEF) return w + 16'h0410 - 16'h00B0;
                if (b <= 8'hFC) return w + 16'h0451 - 16'h00F1;
                return w + 16'h045E - 16'h00FE;
            end
            T_GREEK:
            begin
                if (b <= 8'hB5) return greek_a0(b);
                if (b == 8'hB6) return 16'h0386;
                if (b == 8'hB7 || b == 8'hBB || b == 8'hBD) return w;
                if (b <= 8'hBA) return w + 16'h0388 - 16'h00B8;
                if (b == 8'hBC) return 16'h038C;
                if (b == 8'hD2 || b == 8'hFF) return 16'h0000;
                return w + 16'h038E - 16'h00BE;
            end
            default: return w;
        endcase
    endfunction

endpackage

FILE: rtl/core/dtu_front.sv
// Front end: accepts input bytes, tracks string state and decodes to UTF-8 runs.
`timescale 1ns / 1ps

module dtu_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    input  logic                wr_en,
    input  logic [15:0]         wr_data,
    input  logic                q_full,
    output logic                q_push,
    output dtu_pkg::run_t       q_entry
);
    import dtu_pkg::*;

    phase_t                  phase_reg, phase_next, phase_base;
    table_t                  table_reg, table_next, table_base;
    logic [3:0]              pm_reg, pm_next;
    logic [7:0]              hb_reg, hb_next;
    logic                    hv_reg, hv_next;
    logic [23:0]             sb_reg, sb_next;
    logic [2:0]              sn_reg, sn_next;
    logic [1:0]              sh_reg, sh_next;
    logic [LENGTH_BITS-1:0]  bw_reg, bw_next;
    logic                    st_reg, st_next;
    logic [15:0]             cap_reg, cap_next;

    logic                    accept;
    logic                    restart;
    logic                    do_text;
    logic [3:0][7:0]         ob;
    logic [2:0]              on;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign restart  = first_byte || (phase_reg == PH_SELECT);
    assign phase_base = restart ? PH_SELECT : phase_reg;
    assign table_base = restart ? T_ISO6937 : table_reg;

    // Next phase of the selector parser
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_base)
                PH_SELECT:
                begin
                    if (in_byte == SEL_EXT)
                        phase_next = PH_EXT1;
                    else if (in_byte == SEL_SKIP)
                        phase_next = PH_SKIP1;
                    else
                        phase_next = PH_TEXT;
                end
                PH_EXT1:  phase_next = last_byte ? PH_TEXT : PH_EXT2;
                default:  phase_next = PH_TEXT;
            endcase
            if (last_byte)
                phase_next = PH_SELECT;
        end
    end

    // Table selection and text enable for this beat
    always_comb
    begin
        table_next = table_base;
        do_text    = 1'b0;
        case (phase_base)
            PH_SELECT:
            begin
                if (in_byte >= 8'h20)
                begin
                    table_next = T_ISO6937;
                    do_text    = 1'b1;
                end
                else if (in_byte == SEL_CYR)
                    table_next = T_CYR;
                else if (in_byte == SEL_GREEK)
                    table_next = T_GREEK;
                else if (in_byte == SEL_LATIN5)
                    table_next = T_LATIN5;
                else if (in_byte == SEL_LATIN9)
                    table_next = T_LATIN9;
                else if (in_byte == SEL_UTF16)
                    table_next = T_UTF16;
                else if (in_byte == SEL_UTF8)
                    table_next = T_UTF8;
                else
                    table_next = T_LATIN1;
            end
            PH_EXT1:  do_text = last_byte;
            PH_EXT2:
            begin
                if (in_byte == EXT_CYR)
                    table_next = T_CYR;
                else if (in_byte == EXT_GREEK)
                    table_next = T_GREEK;
                else if (in_byte == EXT_LATIN5)
                    table_next = T_LATIN5;
                else if (in_byte == EXT_LATIN9)
                    table_next = T_LATIN9;
                else
                    table_next = T_LATIN1;
            end
            PH_TEXT:  do_text = 1'b1;
            default:  do_text = 1'b0;
        endcase
    end

    // Decode one text byte into up to four UTF-8 bytes
    always_comb
    begin
        logic [15:0]            c1, c2, mk, cp;
        logic                   u1, u2;
        logic [2:0]             len, idx;
        enc_t                   e1, e2;
        logic [LENGTH_BITS-1:0] bw_b;

        pm_next = restart ? 4'd0  : pm_reg;
        hb_next = restart ? 8'd0  : hb_reg;
        hv_next = restart ? 1'b0  : hv_reg;
        sb_next = restart ? 24'd0 : sb_reg;
        sn_next = restart ? 3'd0  : sn_reg;
        sh_next = restart ? 2'd0  : sh_reg;
        bw_b    = restart ? '0    : bw_reg;
        st_next = restart ? 1'b0  : st_reg;
        bw_next = bw_b;
        ob  = '0;
        on  = 3'd0;
        c1  = 16'h0000;
        c2  = 16'h0000;
        u1  = 1'b0;
        u2  = 1'b0;
        len = 3'd0;
        idx = 3'd0;
        mk  = 16'h0000;
        cp  = 16'h0000;

        if (do_text && !st_next)
        begin
            case (table_next)
                T_UTF8:
                begin
                    if (sn_next == 3'd0)
                    begin
                        if (in_byte < 8'h80)
                            len = 3'd1;
                        else if (in_byte[7:5] == 3'b110)
                            len = 3'd2;
                        else if (in_byte[7:4] == 4'b1110)
                            len = 3'd3;
                        else if (in_byte[7:3] == 5'b11110)
                            len = 3'd4;
                        if (len == 3'd0)
                            st_next = 1'b1;
                        else if (len == 3'd1)
                        begin
                            u1 = 1'b1;
                            c1 = (in_byte < 8'h20 || in_byte == 8'h7F) ? 16'h0020
                                                                         : {8'h00, in_byte};
                        end
                        else
                        begin
                            sb_next = {16'h0000, in_byte};
                            sn_next = len;
                            sh_next = 2'd1;
                        end
                    end
                    else if (({1'b0, sh_next} + 3'd1) < sn_next)
                    begin
                        sb_next = {sb_next[15:0], in_byte};
                        sh_next = sh_next + 2'd1;
                    end
                    else
                    begin
                        if (!room_ok(bw_b, sn_next, cap_reg))
                            st_next = 1'b1;
                        else
                        begin
                            case (sh_next)
                                2'd1: ob = {16'h0000, in_byte, sb_next[7:0]};
                                2'd2: ob = {8'h00, in_byte, sb_next[7:0], sb_next[15:8]};
                                default: ob = {in_byte, sb_next[7:0], sb_next[15:8],
                                               sb_next[23:16]};
                            endcase
                            on      = sn_next;
                            bw_next = bw_b + LENGTH_BITS'(sn_next);
                        end
                        sb_next = 24'd0;
                        sn_next = 3'd0;
                        sh_next = 2'd0;
                    end
                end
                T_UTF16:
                begin
                    if (!hv_next)
                    begin
                        hb_next = in_byte;
                        hv_next = 1'b1;
                    end
                    else
                    begin
                        hv_next = 1'b0;
                        u1      = 1'b1;
                        c1      = {hb_next, in_byte};
                        if (c1 < 16'h0020 || c1 == 16'h007F)
                            c1 = 16'h0020;
                    end
                end
                default:
                begin
                    if (pm_next != 4'd0)
                    begin
                        // Compose mark with the following byte, else letter then mark
                        mk      = mark_code(pm_next);
                        cp      = compose(pm_next, in_byte);
                        pm_next = 4'd0;
                        if (mk != 16'h0000 && in_byte != 8'h00)
                        begin
                            u1 = 1'b1;
                            if (cp != 16'h0000)
                                c1 = cp;
                            else
                            begin
                                c1 = {8'h00, in_byte};
                                c2 = mk;
                                u2 = 1'b1;
                            end
                        end
                    end
                    else if (in_byte < 8'h20 || (in_byte >= 8'h7F && in_byte < 8'hA0))
                    begin
                        u1 = 1'b1;
                        c1 = 16'h0020;
                    end
                    else if (in_byte < 8'hA0)
                    begin
                        u1 = 1'b1;
                        c1 = {8'h00, in_byte};
                    end
                    else if (table_next != T_ISO6937)
                    begin
                        u1 = 1'b1;
                        c1 = high_code(table_next, in_byte);
                    end
                    else if (in_byte >= 8'hC1 && in_byte <= 8'hCF)
                        pm_next = in_byte[3:0];
                    else
                    begin
                        u1 = 1'b1;
                        c1 = t6937_code(in_byte);
                    end
                end
            endcase
        end

        // Encode the code points and check capacity
        e1 = utf8_encode(c1, bw_b, cap_reg);
        e2 = utf8_encode(c2, bw_b + LENGTH_BITS'(e1.n), cap_reg);
        if (u1)
        begin
            if (!e1.ok)
                st_next = 1'b1;
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (k < int'(e1.n))
                        ob[k] = e1.b[k];
                end
                on      = 3'(e1.n);
                bw_next = bw_b + LENGTH_BITS'(e1.n);
                if (u2)
                begin
                    if (!e2.ok)
                        st_next = 1'b1;
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            idx = 3'(e1.n) + 3'(k);
                            if (k < int'(e2.n) && idx < 3'd4)
                                ob[idx[1:0]] = e2.b[k];
                        end
                        on      = 3'(e1.n) + 3'(e2.n);
                        bw_next = bw_next + LENGTH_BITS'(e2.n);
                    end
                end
            end
        end
    end

    // Hand the run to the queue
    always_comb
    begin
        q_push          = accept && ((on != 3'd0) || last_byte);
        q_entry.bytes   = ob;
        q_entry.num     = on;
        q_entry.closing = last_byte;
        q_entry.length  = 16'(bw_next);
    end

    assign cap_next = wr_en ? wr_data : cap_reg;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else
            cap_reg <= cap_next;
    end

    // String state, advanced on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SELECT;
            table_reg <= T_ISO6937;
            pm_reg    <= 4'd0;
            hb_reg    <= 8'd0;
            hv_reg    <= 1'b0;
            sb_reg    <= 24'd0;
            sn_reg    <= 3'd0;
            sh_reg    <= 2'd0;
            bw_reg    <= '0;
            st_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            table_reg <= table_next;
            pm_reg    <= pm_next;
            hb_reg    <= hb_next;
            hv_reg    <= hv_next;
            sb_reg    <= sb_next;
            sn_reg    <= sn_next;
            sh_reg    <= sh_next;
            bw_reg    <= bw_next;
            st_reg    <= st_next;
        end
    end

endmodule

FILE: rtl/core/dtu_queue.sv
// Short run queue between the decoder and the byte serializer.
`timescale 1ns / 1ps

module dtu_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dtu_pkg::run_t push_entry,
    input  logic          pop,
    output dtu_pkg::run_t head,
    output logic          full,
    output logic          empty
);
    import dtu_pkg::*;

    run_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_next  = push ? ((wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed runs
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("run queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("run queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("run queue count out of range");
`endif

endmodule

FILE: rtl/core/dtu_back.sv
// Back end: serializes queued runs into one output beat per byte.
`timescale 1ns / 1ps

module dtu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  dtu_pkg::run_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          run_last,
    output logic          string_end,
    output logic [15:0]   out_length
);
    import dtu_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        bv_reg, bv_next;
    logic        rl_reg, rl_next;
    logic        se_reg, se_next;
    logic [15:0] len_reg, len_next;
    logic        load;
    logic        is_data;
    logic [2:0]  total;

    assign total   = head.num + 3'(head.closing);
    assign load    = !empty && (!ov_reg || out_ready);
    assign is_data = pos_reg < head.num;
    assign pop     = load && (pos_reg == total - 3'd1);

    // Build the next output beat from the head run
    always_comb
    begin
        pos_next = pos_reg;
        ov_next  = ov_reg && !out_ready;
        ob_next  = ob_reg;
        bv_next  = bv_reg;
        rl_next  = rl_reg;
        se_next  = se_reg;
        len_next = len_reg;
        if (load)
        begin
            pos_next = pop ? 3'd0 : pos_reg + 3'd1;
            ov_next  = 1'b1;
            if (is_data)
            begin
                ob_next  = head.bytes[pos_reg[1:0]];
                bv_next  = 1'b1;
                rl_next  = !head.closing && (pos_reg == head.num - 3'd1);
                se_next  = 1'b0;
                len_next = 16'd0;
            end
            else
            begin
                ob_next  = 8'd0;
                bv_next  = 1'b0;
                rl_next  = 1'b1;
                se_next  = 1'b1;
                len_next = head.length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        ob_reg  <= ob_next;
        bv_reg  <= bv_next;
        rl_reg  <= rl_next;
        se_reg  <= se_next;
        len_reg <= len_next;
    end

    assign out_valid  = ov_reg;
    assign out_byte   = ob_reg;
    assign byte_valid = bv_reg;
    assign run_last   = rl_reg;
    assign string_end = se_reg;
    assign out_length = len_reg;

`ifndef ASSERT_OFF
    a_close_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !bv_reg) |-> (se_reg && rl_reg && ob_reg == 8'd0))
        else $error("closing beat malformed");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 3'd4)
        else $error("beat position out of range");
`endif

endmodule

FILE: rtl/core/dvb_text_to_utf8_stream.sv
// Top level of the DVB service-information text to UTF-8 converter.
`timescale 1ns / 1ps

// Takes one byte of a DVB SI string per beat (first_byte/last_byte mark the
// string) and gives UTF-8 output one byte per beat, followed by a closing beat
// (byte_valid low, string_end high, out_length = bytes written) after the last
// input byte. The decoder takes an input beat every cycle while its two-entry
// run queue has room; each input byte yields zero to four data beats, and the last
// byte also the closing beat; the byte-wide output port drains one beat per cycle
// while out_ready is high, so sustained throughput is set by the output port.
// output_capacity is written through wr_en/wr_data and resets to 256.
module dvb_text_to_utf8_stream
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        string_end,
    output logic [15:0] out_length,
    input  logic        wr_en,
    input  logic [15:0] wr_data
);
    import dtu_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    run_t q_in;
    run_t q_head;

    dtu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    dtu_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    dtu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end),
        .out_length (out_length)
    );

endmodule

FILE: bench/tb_dvb_text_to_utf8_stream.sv
// Self-checking testbench for the DVB text to UTF-8 stream converter.
`timescale 1ns / 1ps

module tb_dvb_text_to_utf8_stream;
    import dtu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 170;

    typedef struct {
        logic [7:0]  data;
        logic        data_ok;
        logic        last_of_run;
        logic        closing;
        logic [15:0] length;
    } utf8_beat_t;

    typedef struct {
        logic [7:0]  b;
        logic        f;
        logic        l;
        logic        typed;
        logic        has_data;
        logic [7:0]  d;
        logic [15:0] n;
    } text_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        string_end;
    logic [15:0] out_length;
    logic        wr_en = 1'b0;
    logic [15:0] wr_data = 16'h0000;

    dvb_text_to_utf8_stream dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end),
        .out_length (out_length),
        .wr_en      (wr_en),
        .wr_data    (wr_data)
    );

    always #10 clk = ~clk;

    // Character tables of the decoder under test
    localparam logic [15:0] GREEK_LOW [22] = '{
        16'h00A0, 16'h2018, 16'h2019, 16'h00A3, 16'h20AC, 16'h20AF, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h037A, 16'h00AB, 16'h00AC, 16'h00AD, 16'h0000, 16'h2015,
        16'h00B0, 16'h00B1, 16'h00B2, 16'h00B3, 16'h0384, 16'h0385
    };
    localparam logic [15:0] ISO_A0 [32] = '{
        16'h00A0, 16'h00A1, 16'h00A2, 16'h00A3, 16'h20AC, 16'h00A5, 16'h0000, 16'h00A7,
        16'h00A4, 16'h2018, 16'h201C, 16'h00AB, 16'h2190, 16'h2191, 16'h2192, 16'h2193,
        16'h00B0, 16'h00B1, 16'h00B2, 16'h00B3, 16'h00D7, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00F7, 16'h2019, 16'h201D, 16'h00BB, 16'h00BC, 16'h00BD, 16'h00BE, 16'h00BF
    };
    localparam logic [15:0] ISO_D0 [48] = '{
        16'h2015, 16'h00B9, 16'h00AE, 16'h00A9, 16'h2122, 16'h266A, 16'h00AC, 16'h00A6,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h215B, 16'h215C, 16'h215D, 16'h215E,
        16'h2126, 16'h00C6, 16'h0110, 16'h00AA, 16'h0126, 16'h0000, 16'h0132, 16'h013F,
        16'h0141, 16'h00D8, 16'h0152, 16'h00BA, 16'h00DE, 16'h0166, 16'h014A, 16'h0149,
        16'h0138, 16'h00E6, 16'h0111, 16'h00F0, 16'h0127, 16'h0131, 16'h0133, 16'h0140,
        16'h0142, 16'h00F8, 16'h0153, 16'h00DF, 16'h00FE, 16'h0167, 16'h014B, 16'h00AD
    };
    localparam logic [15:0] MARKS [15] = '{
        16'h0300, 16'h0301, 16'h0302, 16'h0303, 16'h0304, 16'h0306, 16'h0307, 16'h0308,
        16'h0000, 16'h030A, 16'h0327, 16'h0000, 16'h030B, 16'h0328, 16'h030C
    };

    // Directed strings: selectors, marks, unassigned bytes, cut-off sequences
    localparam int NUM_ROWS = 34;
    text_row_t rows [NUM_ROWS] = '{
        '{8'h41, 1, 1, 1, 1, 8'h41, 16'd1},
        '{SEL_UTF8, 1, 1, 1, 0, 8'h00, 16'd0},
        '{8'h00, 1, 1, 1, 0, 8'h00, 16'd0},
        '{8'hC2, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'h65, 0, 1, 0, 0, 8'h00, 16'd0},
        '{8'hC9, 1, 0, 1, 0, 8'h00, 16'd0},
        '{8'h78, 0, 1, 1, 0, 8'h00, 16'd0},
        '{8'hC1, 1, 1, 1, 0, 8'h00, 16'd0},
        '{8'hC8, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'hFF, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'hA6, 0, 1, 0, 0, 8'h00, 16'd0},
        '{SEL_EXT, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'h41, 0, 1, 0, 0, 8'h00, 16'd0},
        '{SEL_EXT, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'h00, 0, 0, 0, 0, 8'h00, 16'd0},
        '{EXT_CYR, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'hB0, 0, 1, 0, 0, 8'h00, 16'd0},
        '{SEL_SKIP, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'h99, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'hFF, 0, 1, 0, 0, 8'h00, 16'd0},
        '{SEL_UTF16, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'h00, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'h07, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'hD8, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'h01, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'h04, 0, 1, 0, 0, 8'h00, 16'd0},
        '{SEL_UTF8, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'hE2, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'h82, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'hAC, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'hE2, 0, 0, 0, 0, 8'h00, 16'd0},
        '{8'h41, 1, 1, 0, 0, 8'h00, 16'd0},
        '{SEL_GREEK, 1, 0, 0, 0, 8'h00, 16'd0},
        '{8'hD2, 0, 1, 0, 0, 8'h00, 16'd0}
    };

    // Decoder state mirrored by the predictor
    phase_t      sel_phase;
    table_t      cur_table;
    int unsigned mark_idx;
    logic [7:0]  utf16_hi;
    logic        utf16_hi_ok;
    logic [23:0] seq_acc;
    int unsigned seq_len;
    int unsigned seq_got;
    int unsigned wr_count;
    logic        halted;
    int unsigned capacity;
    logic [7:0]  step_bytes [4];
    int unsigned step_num;

    utf8_beat_t  pending_beats [$];
    int          errors = 0;
    int          in_beats = 0;
    logic        row_typed = 1'b0;
    logic        row_has_data = 1'b0;
    logic [7:0]  row_data = 8'h00;
    logic [15:0] row_length = 16'h0000;
    int          burst_left = 0;

    function automatic logic [15:0] precompose(input logic [15:0] mark, input logic [7:0] c);
        case ({mark[7:0], c})
            16'h0041: return 16'h00C0; 16'h0045: return 16'h00C8; 16'h0049: return 16'h00CC;
            16'h004F: return 16'h00D2; 16'h0055: return 16'h00D9; 16'h0061: return 16'h00E0;
            16'h0065: return 16'h00E8; 16'h0069: return 16'h00EC; 16'h006F: return 16'h00F2;
            16'h0075: return 16'h00F9;
            16'h0141: return 16'h00C1; 16'h0143: return 16'h0106; 16'h0145: return 16'h00C9;
            16'h0149: return 16'h00CD; 16'h014E: return 16'h0143; 16'h014F: return 16'h00D3;
            16'h0153: return 16'h015A; 16'h0155: return 16'h00DA; 16'h0159: return 16'h00DD;
            16'h015A: return 16'h0179; 16'h0161: return 16'h00E1; 16'h0163: return 16'h0107;
            16'h0165: return 16'h00E9; 16'h0169: return 16'h00ED; 16'h016E: return 16'h0144;
            16'h016F: return 16'h00F3; 16'h0173: return 16'h015B; 16'h0175: return 16'h00FA;
            16'h0179: return 16'h00FD; 16'h017A: return 16'h017A;
            16'h0241: return 16'h00C2; 16'h0245: return 16'h00CA; 16'h0249: return 16'h00CE;
            16'h024F: return 16'h00D4; 16'h0255: return 16'h00DB; 16'h0261: return 16'h00E2;
            16'h0265: return 16'h00EA; 16'h0269: return 16'h00EE; 16'h026F: return 16'h00F4;
            16'h0275: return 16'h00FB;
            16'h0341: return 16'h00C3; 16'h034E: return 16'h00D1; 16'h034F: return 16'h00D5;
            16'h0361: return 16'h00E3; 16'h036E: return 16'h00F1; 16'h036F: return 16'h00F5;
            16'h0641: return 16'h0102; 16'h0647: return 16'h011E; 16'h0661: return 16'h0103;
            16'h0667: return 16'h011F;
            16'h0749: return 16'h0130; 16'h075A: return 16'h017B; 16'h077A: return 16'h017C;
            16'h0841: return 16'h00C4; 16'h0845: return 16'h00CB; 16'h0849: return 16'h00CF;
            16'h084F: return 16'h00D6; 16'h0855: return 16'h00DC; 16'h0859: return 16'h0178;
            16'h0861: return 16'h00E4; 16'h0865: return 16'h00EB; 16'h0869: return 16'h00EF;
            16'h086F: return 16'h00F6; 16'h0875: return 16'h00FC; 16'h0879: return 16'h00FF;
            16'h0A41: return 16'h00C5; 16'h0A55: return 16'h016E; 16'h0A61: return 16'h00E5;
            16'h0A75: return 16'h016F;
            16'h0B4F: return 16'h0150; 16'h0B55: return 16'h0170; 16'h0B6F: return 16'h0151;
            16'h0B75: return 16'h0171;
            16'h0C43: return 16'h010C; 16'h0C44: return 16'h010E; 16'h0C45: return 16'h011A;
            16'h0C4E: return 16'h0147; 16'h0C52: return 16'h0158; 16'h0C53: return 16'h0160;
            16'h0C54: return 16'h0164; 16'h0C5A: return 16'h017D; 16'h0C63: return 16'h010D;
            16'h0C64: return 16'h010F; 16'h0C65: return 16'h011B; 16'h0C6E: return 16'h0148;
            16'h0C72: return 16'h0159; 16'h0C73: return 16'h0161; 16'h0C74: return 16'h0165;
            16'h0C7A: return 16'h017E;
            16'h2743: return 16'h00C7; 16'h2747: return 16'h0122; 16'h2753: return 16'h015E;
            16'h2754: return 16'h0162; 16'h2763: return 16'h00E7; 16'h2767: return 16'h0123;
            16'h2773: return 16'h015F; 16'h2774: return 16'h0163;
            16'h2841: return 16'h0104; 16'h2845: return 16'h0118; 16'h2861: return 16'h0105;
            16'h2865: return 16'h0119;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] table_code(input table_t t, input int unsigned b);
        case (t)
            T_LATIN5:
                case (b)
                    8'hD0: return 16'h011E; 8'hDD: return 16'h0130; 8'hDE: return 16'h015E;
                    8'hF0: return 16'h011F; 8'hFD: return 16'h0131; 8'hFE: return 16'h015F;
                    default: return 16'(b);
                endcase
            T_LATIN9:
                case (b)
                    8'hA4: return 16'h20AC; 8'hA6: return 16'h0160; 8'hA8: return 16'h0161;
                    8'hB4: return 16'h017D; 8'hB8: return 16'h017E; 8'hBC: return 16'h0152;
                    8'hBD: return 16'h0153; 8'hBE: return 16'h0178;
                    default: return 16'(b);
                endcase
            T_CYR:
            begin
                if (b == 'hA0 || b == 'hAD) return 16'(b);
                if (b == 'hF0) return 16'h2116;
                if (b == 'hFD) return 16'h00A7;
                if (b <= 'hAC) return 16'('h0401 + b - 'hA1);
                if (b <= 'hAF) return 16'('h040E + b - 'hAE);
                if (b <= 'hEF) return 16'('h0410 + b - 'hB0);
                if (b <= 'hFC) return 16'('h0451 + b - 'hF1);
                return 16'('h045E + b - 'hFE);
            end
            T_GREEK:
            begin
                if (b <= 'hB5) return GREEK_LOW[b - 'hA0];
                if (b == 'hB6) return 16'h0386;
                if (b == 'hB7 || b == 'hBB || b == 'hBD) return 16'(b);
                if (b <= 'hBA) return 16'('h0388 + b - 'hB8);
                if (b == 'hBC) return 16'h038C;
                if (b == 'hD2 || b == 'hFF) return 16'h0000;
                return 16'('h038E + b - 'hBE);
            end
            default: return 16'(b);
        endcase
    endfunction

    // Append one code point as UTF-8 if it fits; set halted otherwise
    function automatic logic put_code(input int unsigned code);
        int unsigned need;
        need = code < 'h80 ? 1 : code < 'h800 ? 2 : 3;
        if (code == 0) return 1'b1;
        if (wr_count + need + 1 > capacity || wr_count + need > 65535 || step_num + need > 4)
        begin
            halted = 1'b1;
            return 1'b0;
        end
        if (need == 1)
        begin
            step_bytes[step_num++] = code[7:0];
        end
        else if (need == 2)
        begin
            step_bytes[step_num++] = 8'hC0 | code[10:6];
            step_bytes[step_num++] = 8'h80 | code[5:0];
        end
        else
        begin
            step_bytes[step_num++] = 8'hE0 | code[15:12];
            step_bytes[step_num++] = 8'h80 | code[11:6];
            step_bytes[step_num++] = 8'h80 | code[5:0];
        end
        wr_count += need;
        return 1'b1;
    endfunction

    function automatic void decode_single(input int unsigned ch);
        logic [15:0] mark;
        logic [15:0] code;
        if (mark_idx != 0)
        begin
            mark     = MARKS[mark_idx - 1];
            mark_idx = 0;
            if (mark == 0 || ch == 0) return;
            code = precompose(mark, ch[7:0]);
            if (code != 0) void'(put_code(code));
            else if (put_code(ch)) void'(put_code(mark));
            return;
        end
        if (ch < 'h20 || (ch >= 'h7F && ch < 'hA0)) void'(put_code('h20));
        else if (ch < 'hA0) void'(put_code(ch));
        else if (cur_table != T_ISO6937) void'(put_code(table_code(cur_table, ch)));
        else if (ch >= 'hC1 && ch <= 'hCF) mark_idx = ch - 'hC0;
        else if (ch < 'hC0) void'(put_code(ISO_A0[ch - 'hA0]));
        else if (ch >= 'hD0) void'(put_code(ISO_D0[ch - 'hD0]));
    endfunction

    function automatic void decode_utf8(input int unsigned ch);
        int unsigned len;
        if (seq_len == 0)
        begin
            len = ch < 'h80 ? 1 : (ch & 'hE0) == 'hC0 ? 2 : (ch & 'hF0) == 'hE0 ? 3
                : (ch & 'hF8) == 'hF0 ? 4 : 0;
            if (len == 0) halted = 1'b1;
            else if (len == 1) void'(put_code((ch < 'h20 || ch == 'h7F) ? 'h20 : ch));
            else
            begin
                seq_acc = 24'(ch);
                seq_len = len;
                seq_got = 1;
            end
            return;
        end
        if (seq_got + 1 < seq_len)
        begin
            seq_acc = {seq_acc[15:0], ch[7:0]};
            seq_got++;
            return;
        end
        if (wr_count + seq_len + 1 > capacity || wr_count + seq_len > 65535) halted = 1'b1;
        else
        begin
            for (int i = seq_got; i > 0; i--) step_bytes[step_num++] = seq_acc[8*(i-1) +: 8];
            step_bytes[step_num++] = ch[7:0];
            wr_count += seq_len;
        end
        seq_acc = '0;
        seq_len = 0;
        seq_got = 0;
    endfunction

    function automatic void decode_text(input int unsigned ch);
        int unsigned code;
        if (halted) return;
        if (cur_table == T_UTF8) decode_utf8(ch);
        else if (cur_table == T_UTF16)
        begin
            if (!utf16_hi_ok)
            begin
                utf16_hi    = ch[7:0];
                utf16_hi_ok = 1'b1;
            end
            else
            begin
                code        = {utf16_hi, ch[7:0]};
                utf16_hi_ok = 1'b0;
                if (code < 'h20 || code == 'h7F) code = 'h20;
                void'(put_code(code));
            end
        end
        else decode_single(ch);
    endfunction

    function automatic void clear_string();
        sel_phase   = PH_SELECT;
        cur_table   = T_ISO6937;
        mark_idx    = 0;
        utf16_hi    = '0;
        utf16_hi_ok = 1'b0;
        seq_acc     = '0;
        seq_len     = 0;
        seq_got     = 0;
        wr_count    = 0;
        halted      = 1'b0;
    endfunction

    // Advance the decoder by one input byte; return the beats it yields
    function automatic void convert_byte(input logic [7:0] b, input logic f, input logic l,
                                         output utf8_beat_t beats [$]);
        int unsigned ch;
        ch       = b;
        step_num = 0;
        beats    = {};
        if (f || sel_phase == PH_SELECT) clear_string();
        case (sel_phase)
            PH_SELECT:
            begin
                sel_phase = PH_TEXT;
                if (ch >= 'h20) decode_text(ch);
                else
                begin
                    case (b)
                        SEL_CYR:    cur_table = T_CYR;
                        SEL_GREEK:  cur_table = T_GREEK;
                        SEL_LATIN5: cur_table = T_LATIN5;
                        SEL_LATIN9: cur_table = T_LATIN9;
                        SEL_UTF16:  cur_table = T_UTF16;
                        SEL_UTF8:   cur_table = T_UTF8;
                        default:    cur_table = T_LATIN1;
                    endcase
                    if (b == SEL_EXT) sel_phase = PH_EXT1;
                    if (b == SEL_SKIP) sel_phase = PH_SKIP1;
                end
            end
            PH_EXT1:
            begin
                if (l)
                begin
                    sel_phase = PH_TEXT;
                    decode_text(ch);
                end
                else sel_phase = PH_EXT2;
            end
            PH_EXT2:
            begin
                case (b)
                    EXT_CYR:    cur_table = T_CYR;
                    EXT_GREEK:  cur_table = T_GREEK;
                    EXT_LATIN5: cur_table = T_LATIN5;
                    EXT_LATIN9: cur_table = T_LATIN9;
                    default:    cur_table = T_LATIN1;
                endcase
                sel_phase = PH_TEXT;
            end
            PH_SKIP1: sel_phase = PH_TEXT;
            default: decode_text(ch);
        endcase
        for (int i = 0; i < step_num; i++)
            beats.push_back('{step_bytes[i], 1'b1, !l && i == step_num - 1, 1'b0, 16'h0});
        if (l)
        begin
            beats.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 16'(wr_count)});
            sel_phase = PH_SELECT;
        end
    endfunction

    task automatic report(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    // Predict on every accepted input beat; track register writes
    always @(posedge clk)
    begin
        utf8_beat_t beats [$];
        if (rst_n && in_valid && in_ready)
        begin
            convert_byte(in_byte, first_byte, last_byte, beats);
            if (row_typed)
            begin
                beats = {};
                if (row_has_data) beats.push_back('{row_data, 1'b1, !last_byte, 1'b0, 16'h0});
                if (last_byte) beats.push_back('{8'h00, 1'b0, 1'b1, 1'b1, row_length});
            end
            foreach (beats[i]) pending_beats.push_back(beats[i]);
            in_beats++;
        end
        if (rst_n && wr_en) capacity = wr_data;
    end

    // Check every accepted output beat against the oldest expectation
    always @(posedge clk)
    begin
        utf8_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: output beat with nothing expected", $realtime);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_byte !== want.data) report("out_byte", out_byte, want.data);
                if (byte_valid !== want.data_ok) report("byte_valid", byte_valid, want.data_ok);
                if (run_last !== want.last_of_run) report("run_last", run_last, want.last_of_run);
                if (string_end !== want.closing) report("string_end", string_end, want.closing);
                if (out_length !== want.length) report("out_length", out_length, want.length);
            end
        end
    end

    // Stall the output side: free-running, random, then a fixed pattern
    always @(negedge clk)
    begin
        int unsigned cyc;
        cyc++;
        case ((cyc / 150) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 3) != 0;
            default: out_ready <= (cyc % 5) != 3;
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive one input beat in bursts with random gaps; hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        int gap;
        int seen;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        in_byte    <= b;
        first_byte <= f;
        last_byte  <= l;
        seen = in_beats;
        @(negedge clk);
        while (in_beats == seen) @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        row_typed = 1'b0;
        while (pending_beats.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(negedge clk);
        wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Build one random string, mostly well formed
    task automatic send_string(inout int sent);
        logic [7:0] text [$];
        logic [7:0] letters [20] = '{"A", "E", "I", "O", "U", "a", "c", "e", "g", "n",
                                     "o", "s", "t", "u", "y", "z", "C", "N", "S", "Z"};
        int kind;
        int n;
        int len;
        logic f;
        logic cut;
        kind = $urandom_range(0, 11);
        n    = $urandom_range(0, 7);
        case (kind)
            0, 1: text.push_back(8'($urandom_range(8'h20, 8'hFF)));
            2: text.push_back(SEL_CYR);
            3: text.push_back(SEL_GREEK);
            4: text.push_back(SEL_LATIN5);
            5: text.push_back(SEL_LATIN9);
            6: text = {SEL_EXT, 8'($urandom), 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                : 2 * $urandom_range(2, 7) + 1)};
            7: text.push_back(SEL_UTF16);
            8, 9: text.push_back(SEL_UTF8);
            10: text = {SEL_SKIP, 8'($urandom)};
            default: text.push_back(8'($urandom_range(0, 8'h1F)));
        endcase
        while (n > 0)
        begin
            if ((kind == 8 || kind == 9) && $urandom_range(0, 7) != 0)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1: text.push_back(8'($urandom_range(0, 8'h7F)));
                    2: text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    3: text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                endcase
                repeat (len - 1) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (kind < 2 && $urandom_range(0, 2) == 0)
            begin
                text.push_back(8'($urandom_range(8'hC1, 8'hCF)));
                text.push_back(letters[$urandom_range(0, 19)]);
            end
            else text.push_back(8'($urandom));
            n--;
        end
        cut = $urandom_range(0, 9) == 0;
        f   = $urandom_range(0, 5) != 0;
        foreach (text[i])
        begin
            send_byte(text[i], i == 0 ? f : ($urandom_range(0, 40) == 0),
                      !cut && i == text.size() - 1);
            sent++;
        end
    endtask

    initial
    begin
        logic [15:0] caps [5];
        int sent;
        clear_string();
        capacity = CAP_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings at the reset capacity
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row_typed    = rows[r].typed;
            row_has_data = rows[r].has_data;
            row_data     = rows[r].d;
            row_length   = rows[r].n;
            send_byte(rows[r].b, rows[r].f, rows[r].l);
        end
        // Start a string without the first mark after one has ended
        row_typed    = 1'b1;
        row_has_data = 1'b1;
        row_data     = 8'h42;
        row_length   = 16'd1;
        send_byte(8'h42, 1'b0, 1'b1);
        wait_idle();

        // Random strings across capacity settings
        caps = '{16'd0, 16'hFFFF, 16'd3, 16'd9, 16'($urandom_range(2, 40))};
        sent = 0;
        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            while (sent < RANDOM_ITEMS * (p + 1) / 5) send_string(sent);
            send_byte(8'h20, 1'b0, 1'b1);
            wait_idle();
        end
        write_capacity(CAP_RESET);
        repeat (2) send_string(sent);
        send_byte(8'h20, 1'b0, 1'b1);
        wait_idle();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
